[design/assert_macros.svh]
// Assertion macros shared by the tile map render core.
// Holds only macro definitions; tsr_div_pipe and tsr_lookup include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication in the same clock cycle.
`define TSR_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Checks an implication in the following clock cycle.
`define TSR_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[design/tsr_pkg.sv]
// Shared types, codes and widths of the tile map render core.
// No dependencies; tsr_div_pipe, tsr_lookup and the top level import it.
`timescale 1ns / 1ps

package tsr_pkg;

   // Default sizes of the stores.
   localparam int MAP_SIZE_MAX_DEF = 128;
   localparam int TILE_COUNT_DEF   = 64;
   localparam int TILE_DIM         = 64;
   localparam int TILE_TEXELS      = TILE_DIM * TILE_DIM;

   // Field widths.
   localparam int CMD_W   = 2;
   localparam int POS_W   = 12;
   localparam int TILE_W  = 6;
   localparam int TEX_W   = 6;
   localparam int COLOR_W = 8;
   localparam int MSIZE_W = 8;
   localparam int SIZE_W  = 9;
   localparam int LEN_W   = 13;
   localparam int TIDX_W  = 8;
   localparam int PROD_W  = POS_W + SIZE_W;
   localparam int DIV_W   = PROD_W + TEX_W;
   localparam int RGB_W   = 3 * COLOR_W;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = RGB_W;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_MAP     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TEXEL   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PALETTE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RENDER  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [TILE_W-1:0]  tile_number;
      logic [TEX_W-1:0]   texel_x;
      logic [TEX_W-1:0]   texel_y;
      logic [COLOR_W-1:0] color_index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } item_type;

   // Effective configuration seen by the datapath.
   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic [LEN_W-1:0]  width;
      logic [LEN_W-1:0]  height;
   } cfg_type;

   // One lane of the restoring divider: partial remainder and shifting quotient.
   typedef struct packed {
      logic [LEN_W-1:0] rem;
      logic [DIV_W-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      item_type     item;
      div_lane_type lane_x;
      div_lane_type lane_y;
   } div_stage_type;

   // One restoring division step: brings in one dividend bit, emits one quotient bit.
   function automatic div_lane_type div_step(div_lane_type lane, logic [LEN_W-1:0] divisor);
      logic [LEN_W:0] trial;
      logic           fits;
      div_lane_type   res;
      trial   = {lane.rem, lane.quo[DIV_W-1]};
      fits    = trial >= {1'b0, divisor};
      res.rem = fits ? LEN_W'(trial - {1'b0, divisor}) : trial[LEN_W-1:0];
      res.quo = {lane.quo[DIV_W-2:0], fits};
      return res;
   endfunction

endpackage

[design/tsr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds while the read is not enabled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tsr_div_pipe.sv]
// Input register, coordinate scaling multiply and pipelined restoring dividers.
// Depends on tsr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsr_div_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  tsr_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tsr_pkg::item_type      in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tsr_pkg::div_stage_type out_stage
);
   import tsr_pkg::*;

   // Stage 0 registers the item, stage 1 the products, then one quotient bit per stage.
   localparam int LAST = DIV_W + 1;

   div_stage_type   stage_ff [LAST+1];
   div_stage_type   stage_in [LAST+1];
   logic [LAST:0]   valid_ff;
   logic [LAST:0]   valid_in;
   logic [LAST:0]   adv;
   logic [PROD_W-1:0] prod_x;
   logic [PROD_W-1:0] prod_y;

   // Stage 0 takes the raw item.
   always_comb begin
      stage_in[0]        = '0;
      stage_in[0].item   = in_item;
      valid_in[0]        = in_valid;
   end

   // Stage 1 scales the pixel position by the map size; the dividend carries 6 extra bits.
   always_comb begin
      prod_x = PROD_W'(stage_ff[0].item.pos_x) * PROD_W'(cfg.size);
      prod_y = PROD_W'(stage_ff[0].item.pos_y) * PROD_W'(cfg.size);
      stage_in[1]            = '0;
      stage_in[1].item       = stage_ff[0].item;
      stage_in[1].lane_x.quo = {prod_x, TEX_W'(0)};
      stage_in[1].lane_y.quo = {prod_y, TEX_W'(0)};
      valid_in[1]            = valid_ff[0];
   end

   // Divider stages.
   for (genvar k = 2; k <= LAST; k++) begin : g_step
      always_comb begin
         stage_in[k].item   = stage_ff[k-1].item;
         stage_in[k].lane_x = div_step(stage_ff[k-1].lane_x, cfg.width);
         stage_in[k].lane_y = div_step(stage_ff[k-1].lane_y, cfg.height);
         valid_in[k]        = valid_ff[k-1];
      end
   end

   // A stage moves when it is empty or the stage after it moves.
   for (genvar k = 0; k <= LAST; k++) begin : g_stage
      if (k == LAST) begin : g_tail
         assign adv[k] = !valid_ff[k] || out_ready;
      end else begin : g_body
         assign adv[k] = !valid_ff[k] || adv[k+1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= valid_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[LAST];
   assign out_stage = stage_ff[LAST];

   // A stalled tail keeps its transaction.
   `TSR_ASSERT_NEXT(a_tail_hold, clock, reset, valid_ff[LAST] && !out_ready,
      valid_ff[LAST] && $stable(stage_ff[LAST].item), "divider tail lost a stalled transaction")
   // The input can only be blocked when the tail is holding a transaction.
   `TSR_ASSERT_NOW(a_block_full, clock, reset, !in_ready, valid_ff[LAST] && !out_ready,
      "divider blocked input without a stalled tail")

endmodule

[design/tsr_lookup.sv]
// Tile index saturation and the map, texel and palette lookups, in order with writes.
// Depends on tsr_pkg, tsr_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsr_lookup #(
   parameter int MAP_SIZE_MAX = tsr_pkg::MAP_SIZE_MAX_DEF,
   parameter int TILE_COUNT   = tsr_pkg::TILE_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [tsr_pkg::SIZE_W-1:0]       size,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  tsr_pkg::div_stage_type           in_stage,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [tsr_pkg::RSP_DATA_W-1:0]   out_data
);
   import tsr_pkg::*;

   localparam int MAP_DEPTH = MAP_SIZE_MAX * MAP_SIZE_MAX;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam int TEX_DEPTH = TILE_COUNT * TILE_TEXELS;
   localparam int TEX_AW    = $clog2(TEX_DEPTH);
   localparam int QHI_W     = DIV_W - TEX_W;

   logic [3:0] valid_ff;
   logic [3:0] adv;

   item_type          l0_item_ff, l1_item_ff, l2_item_ff;
   logic [TIDX_W-1:0] tile_x_ff, tile_y_ff;
   logic [TIDX_W-1:0] tile_x_in, tile_y_in;
   logic [TEX_W-1:0]  l0_tex_x_ff, l0_tex_y_ff, l1_tex_x_ff, l1_tex_y_ff;
   logic              map_ok_ff, map_ok_in;

   logic [QHI_W-1:0]   quo_x, quo_y;
   logic [POS_W-1:0]   map_row, map_col;
   logic [MAP_AW-1:0]  map_addr;
   logic [TILE_W-1:0]  map_rd;
   logic               map_we;
   logic [TILE_W-1:0]  tile_sel;
   logic [TEX_AW-1:0]  tex_addr;
   logic [COLOR_W-1:0] tex_rd;
   logic               tex_we;
   logic [COLOR_W-1:0] pal_addr;
   logic               pal_we;

   // Handshake chain through the four lookup stages.
   assign adv[3]   = !valid_ff[3] || out_ready;
   assign adv[2]   = !valid_ff[2] || adv[3];
   assign adv[1]   = !valid_ff[1] || adv[2];
   assign adv[0]   = !valid_ff[0] || adv[1];
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         if (adv[1]) valid_ff[1] <= valid_ff[0];
         if (adv[2]) valid_ff[2] <= valid_ff[1];
         if (adv[3]) valid_ff[3] <= valid_ff[2] && (l2_item_ff.cmd == CMD_RENDER);
      end
   end

   // Stage 0: clamp the tile index to the map and check map writes.
   always_comb begin
      quo_x     = in_stage.lane_x.quo[DIV_W-1:TEX_W];
      quo_y     = in_stage.lane_y.quo[DIV_W-1:TEX_W];
      tile_x_in = (quo_x >= QHI_W'(size)) ? TIDX_W'(size - 1'b1) : quo_x[TIDX_W-1:0];
      tile_y_in = (quo_y >= QHI_W'(size)) ? TIDX_W'(size - 1'b1) : quo_y[TIDX_W-1:0];
      map_ok_in = (in_stage.item.pos_x < POS_W'(size)) && (in_stage.item.pos_y < POS_W'(size))
                  && (32'(in_stage.item.tile_number) < TILE_COUNT);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         l0_item_ff  <= in_stage.item;
         tile_x_ff   <= tile_x_in;
         tile_y_ff   <= tile_y_in;
         l0_tex_x_ff <= in_stage.lane_x.quo[TEX_W-1:0];
         l0_tex_y_ff <= in_stage.lane_y.quo[TEX_W-1:0];
         map_ok_ff   <= map_ok_in;
      end
   end

   // Tile map access: write cells in order, read the cell under the pixel.
   always_comb begin
      if (l0_item_ff.cmd == CMD_MAP) begin
         map_row = l0_item_ff.pos_y;
         map_col = l0_item_ff.pos_x;
      end else begin
         map_row = POS_W'(tile_y_ff);
         map_col = POS_W'(tile_x_ff);
      end
      map_addr = MAP_AW'(32'(map_row) * MAP_SIZE_MAX + 32'(map_col));
      map_we   = valid_ff[0] && adv[1] && (l0_item_ff.cmd == CMD_MAP) && map_ok_ff;
   end

   tsr_ram #(.WIDTH(TILE_W), .DEPTH(MAP_DEPTH)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_addr),
      .wr_data (l0_item_ff.tile_number),
      .rd_en   (adv[1]),
      .rd_addr (map_addr),
      .rd_data (map_rd)
   );

   // Stage 1 payload travels next to the map read data.
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         l1_item_ff  <= l0_item_ff;
         l1_tex_x_ff <= l0_tex_x_ff;
         l1_tex_y_ff <= l0_tex_y_ff;
      end
   end

   // Texel access: tile numbers beyond the tile count fall back to tile zero.
   always_comb begin
      tile_sel = (32'(map_rd) < TILE_COUNT) ? map_rd : '0;
      if (l1_item_ff.cmd == CMD_TEXEL) begin
         tex_addr = TEX_AW'(32'(l1_item_ff.tile_number) * TILE_TEXELS
                    + 32'(l1_item_ff.texel_y) * TILE_DIM + 32'(l1_item_ff.texel_x));
      end else begin
         tex_addr = TEX_AW'(32'(tile_sel) * TILE_TEXELS
                    + 32'(l1_tex_y_ff) * TILE_DIM + 32'(l1_tex_x_ff));
      end
      tex_we = valid_ff[1] && adv[2] && (l1_item_ff.cmd == CMD_TEXEL)
               && (32'(l1_item_ff.tile_number) < TILE_COUNT);
   end

   tsr_ram #(.WIDTH(COLOR_W), .DEPTH(TEX_DEPTH)) u_texel_ram (
      .clock   (clock),
      .wr_en   (tex_we),
      .wr_addr (tex_addr),
      .wr_data (l1_item_ff.color_index),
      .rd_en   (adv[2]),
      .rd_addr (tex_addr),
      .rd_data (tex_rd)
   );

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         l2_item_ff <= l1_item_ff;
      end
   end

   // Palette access; its read register is the result register.
   always_comb begin
      pal_addr = (l2_item_ff.cmd == CMD_PALETTE) ? l2_item_ff.color_index : tex_rd;
      pal_we   = valid_ff[2] && adv[3] && (l2_item_ff.cmd == CMD_PALETTE);
   end

   tsr_ram #(.WIDTH(RGB_W), .DEPTH(256)) u_palette_ram (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (pal_addr),
      .wr_data ({l2_item_ff.red, l2_item_ff.green, l2_item_ff.blue}),
      .rd_en   (adv[3]),
      .rd_addr (pal_addr),
      .rd_data (out_data)
   );

   assign out_valid = valid_ff[3];

   // A result that is not taken stays presented.
   `TSR_ASSERT_NEXT(a_rsp_hold, clock, reset, valid_ff[3] && !out_ready, valid_ff[3],
      "pixel result dropped before it was taken")

endmodule

[design/tilemap_scaled_pixel_render_core.sv]
// Top level of the tile map render core: register port, stream ports, pipeline.
// Depends on tsr_pkg, tsr_div_pipe, tsr_lookup and tsr_ram.
//
// Use: write map_size (0x0), out_width (0x4) and out_height (0x8) over the
// register port while the core is idle. Then stream commands on the req_
// channel: map cell, texel and palette writes fill the stores, and each render
// command returns one pixel on the rsp_ channel, in command order. Writes
// produce no result transaction.
// Throughput is one command per clock cycle while rsp_tready is high. A render
// result passes one input register, one scaling multiply,
// 27 restoring division steps (one quotient bit per stage for both axes),
// and four lookup stages through the map, texel and palette RAMs.
// Writes travel the same pipeline and update each store at the stage where
// renders read it, so every render sees exactly the writes issued before it.
// Reset clears the pipeline valid bits and sets the registers to map size 64
// and a 256 by 256 picture; the stores are not cleared.
// When rsp_tready is low the result holds, and the stages behind it keep
// filling until the pipeline is full; only then req_tready drops.
`timescale 1ns / 1ps

module tilemap_scaled_pixel_render_core #(
   parameter int MAP_SIZE_MAX = tsr_pkg::MAP_SIZE_MAX_DEF,
   parameter int TILE_COUNT   = tsr_pkg::TILE_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // command[1:0], pos_x[13:2], pos_y[25:14], tile_number[31:26], texel_x[37:32],
   // texel_y[43:38], color_index[51:44], red[59:52], green[67:60], blue[75:68]
   input  logic [tsr_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_blue[7:0], out_green[15:8], out_red[23:16]
   output logic [tsr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [3:0]                      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import tsr_pkg::*;

   localparam logic [1:0] REG_MAP_SIZE   = 2'd0;
   localparam logic [1:0] REG_OUT_WIDTH  = 2'd1;
   localparam logic [1:0] REG_OUT_HEIGHT = 2'd2;

   logic [MSIZE_W-1:0] map_size_ff;
   logic [LEN_W-1:0]   out_width_ff, out_height_ff;
   logic               csr_write;
   logic [1:0]         csr_index;
   cfg_type            cfg;
   item_type           req_item;
   logic               mid_valid, mid_ready;
   div_stage_type      mid_stage;

   // Register port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         map_size_ff   <= MSIZE_W'(64);
         out_width_ff  <= LEN_W'(256);
         out_height_ff <= LEN_W'(256);
      end else if (csr_write) begin
         case (csr_index)
            REG_MAP_SIZE:   map_size_ff   <= csr_pwdata[MSIZE_W-1:0];
            REG_OUT_WIDTH:  out_width_ff  <= csr_pwdata[LEN_W-1:0];
            REG_OUT_HEIGHT: out_height_ff <= csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_MAP_SIZE:   csr_prdata = 32'(map_size_ff);
         REG_OUT_WIDTH:  csr_prdata = 32'(out_width_ff);
         REG_OUT_HEIGHT: csr_prdata = 32'(out_height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Effective configuration: size clamped between 16 and the map maximum, zero lengths used as one.
   always_comb begin
      if (map_size_ff < MSIZE_W'(16)) begin
         cfg.size = SIZE_W'(16);
      end else if (32'(map_size_ff) > MAP_SIZE_MAX) begin
         cfg.size = SIZE_W'(MAP_SIZE_MAX);
      end else begin
         cfg.size = SIZE_W'(map_size_ff);
      end
      cfg.width  = (out_width_ff  == '0) ? LEN_W'(1) : out_width_ff;
      cfg.height = (out_height_ff == '0) ? LEN_W'(1) : out_height_ff;
   end

   // Unpack the request transaction.
   always_comb begin
      req_item.cmd         = req_tdata[1:0];
      req_item.pos_x       = req_tdata[13:2];
      req_item.pos_y       = req_tdata[25:14];
      req_item.tile_number = req_tdata[31:26];
      req_item.texel_x     = req_tdata[37:32];
      req_item.texel_y     = req_tdata[43:38];
      req_item.color_index = req_tdata[51:44];
      req_item.red         = req_tdata[59:52];
      req_item.green       = req_tdata[67:60];
      req_item.blue        = req_tdata[75:68];
   end

   tsr_div_pipe u_div_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_stage (mid_stage)
   );

   tsr_lookup #(.MAP_SIZE_MAX(MAP_SIZE_MAX), .TILE_COUNT(TILE_COUNT)) u_lookup (
      .clock     (clock),
      .reset     (reset),
      .size      (cfg.size),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_stage  (mid_stage),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule
